[hw/rtl/cvg_pkg.sv]
// Shared constants, types and helper functions of the cone vertex generator.
`timescale 1ns / 1ps

package cvg_pkg;

  localparam int MAX_SIDES_DEF = 256;

  localparam int IDX_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT        = 2'd0,
    REG_BOTTOM_RADIUS = 2'd1,
    REG_TOP_RADIUS    = 2'd2,
    REG_SIDE_COUNT    = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] HEIGHT_RST = 16'd256;
  localparam logic [15:0] BOTTOM_RST = 16'd256;
  localparam logic [15:0] TOP_RST    = 16'd0;
  localparam logic [8:0]  SIDES_RST  = 9'd16;

  localparam logic [15:0] TEX_HALF = 16'd16384;
  localparam logic [15:0] TEX_ONE  = 16'd32768;

  // Q1.30 fixed point constants for the angle and series evaluation.
  localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
  localparam logic [29:0] QUARTER_PI_Q30 = 30'd843314857;

  // Sine and cosine series: four divide rounds, three stages each, plus two.
  localparam int SC_ROUNDS = 4;
  localparam int SC_LAT    = 3 * SC_ROUNDS + 2;

  localparam logic [6:0] SIN_DIV [SC_ROUNDS] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0] COS_DIV [SC_ROUNDS] = '{7'd90, 7'd56, 7'd30, 7'd12};

  // floor(2^31 / d); the product estimate is low by at most one.
  localparam logic [29:0] SIN_RCP [SC_ROUNDS] = '{
    30'((64'd1 << 31) / 64'd72), 30'((64'd1 << 31) / 64'd42),
    30'((64'd1 << 31) / 64'd20), 30'((64'd1 << 31) / 64'd6)
  };
  localparam logic [29:0] COS_RCP [SC_ROUNDS] = '{
    30'((64'd1 << 31) / 64'd90), 30'((64'd1 << 31) / 64'd56),
    30'((64'd1 << 31) / 64'd30), 30'((64'd1 << 31) / 64'd12)
  };

  // Corrects a reciprocal quotient estimate that may be one too small.
  function automatic logic [29:0] div_fix(input logic [29:0] y, input logic [29:0] q0,
                                          input logic [6:0] d);
    logic [36:0] rem;
    rem = 37'(y) - 37'(q0) * 37'(d);
    return (rem >= 37'(d)) ? 30'(q0 + 30'd1) : q0;
  endfunction

endpackage

[hw/rtl/cvg_ifs.sv]
// Handshake channel interfaces of the cone vertex generator.
`timescale 1ns / 1ps

interface cvg_req_if;
  import cvg_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] vertex_index;
  modport source (output valid, output vertex_index, input ready);
  modport sink   (input valid, input vertex_index, output ready);
endinterface

interface cvg_rsp_if;
  logic               valid;
  logic               ready;
  logic               present;
  logic               is_final;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [15:0]        tex_u;
  logic [15:0]        tex_v;
  modport source (output valid, output present, output is_final, output pos_x,
                  output pos_y, output pos_z, output tex_u, output tex_v, input ready);
  modport sink   (input valid, input present, input is_final, input pos_x,
                  input pos_y, input pos_z, input tex_u, input tex_v, output ready);
endinterface

interface cvg_cfg_if;
  import cvg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/cvg_sincos.sv]
// Pipelined fixed point sine and cosine over the first octant.
`timescale 1ns / 1ps

module cvg_sincos
  import cvg_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [29:0] angle,
  output logic [30:0] sin_q,
  output logic [30:0] cos_q
);

  logic [29:0] m_x  [SC_ROUNDS];
  logic [29:0] m_x2 [SC_ROUNDS];
  logic [29:0] m_ys [SC_ROUNDS];
  logic [29:0] m_yc [SC_ROUNDS];
  logic [29:0] d_x  [SC_ROUNDS];
  logic [29:0] d_x2 [SC_ROUNDS];
  logic [29:0] d_ys [SC_ROUNDS];
  logic [29:0] d_yc [SC_ROUNDS];
  logic [29:0] d_qs [SC_ROUNDS];
  logic [29:0] d_qc [SC_ROUNDS];
  logic [29:0] c_x  [SC_ROUNDS];
  logic [29:0] c_x2 [SC_ROUNDS];
  logic [30:0] c_ts [SC_ROUNDS];
  logic [30:0] c_tc [SC_ROUNDS];

  logic [30:0] f_s;
  logic [29:0] f_pc;

  for (genvar r = 0; r < SC_ROUNDS; r++) begin : g_round
    logic [60:0] ps;
    logic [60:0] pc;
    logic [60:0] qs;
    logic [60:0] qc;

    // Round zero squares the angle; later rounds multiply x^2 by the running term.
    if (r == 0) begin : g_sq
      assign ps = 61'(angle) * 61'(angle);
      assign pc = ps;
      always_ff @(posedge clk) begin
        if (en) begin
          m_x[r]  <= angle;
          m_x2[r] <= ps[59:30];
          m_ys[r] <= ps[59:30];
          m_yc[r] <= ps[59:30];
        end
      end
    end else begin : g_mul
      assign ps = 61'(c_x2[r-1]) * 61'(c_ts[r-1]);
      assign pc = 61'(c_x2[r-1]) * 61'(c_tc[r-1]);
      always_ff @(posedge clk) begin
        if (en) begin
          m_x[r]  <= c_x[r-1];
          m_x2[r] <= c_x2[r-1];
          m_ys[r] <= ps[59:30];
          m_yc[r] <= pc[59:30];
        end
      end
    end

    assign qs = 61'(m_ys[r]) * 61'(SIN_RCP[r]);
    assign qc = 61'(m_yc[r]) * 61'(COS_RCP[r]);

    always_ff @(posedge clk) begin
      if (en) begin
        d_x[r]  <= m_x[r];
        d_x2[r] <= m_x2[r];
        d_ys[r] <= m_ys[r];
        d_yc[r] <= m_yc[r];
        d_qs[r] <= qs[60:31];
        d_qc[r] <= qc[60:31];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_x[r]  <= d_x[r];
        c_x2[r] <= d_x2[r];
        c_ts[r] <= Q30_ONE - 31'(div_fix(d_ys[r], d_qs[r], SIN_DIV[r]));
        c_tc[r] <= Q30_ONE - 31'(div_fix(d_yc[r], d_qc[r], COS_DIV[r]));
      end
    end
  end

  logic [60:0] fin_s;
  logic [60:0] fin_c;
  assign fin_s = 61'(c_x[SC_ROUNDS-1]) * 61'(c_ts[SC_ROUNDS-1]);
  assign fin_c = 61'(c_x2[SC_ROUNDS-1]) * 61'(c_tc[SC_ROUNDS-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      f_s   <= fin_s[60:30];
      f_pc  <= fin_c[59:30];
      sin_q <= f_s;
      cos_q <= Q30_ONE - 31'(f_pc >> 1);
    end
  end

endmodule

[hw/rtl/cone_vertex_generator_core.sv]
// Throughput: one vertex per cycle; every stage advances together, and the
// whole pipeline holds while a finished result waits for its transfer.
// The long division of the ring angle runs four bits per stage over eight stages.
// Reset clears all valid bits and loads the default cone configuration.
`timescale 1ns / 1ps

module cone_vertex_generator_core
  import cvg_pkg::*;
#(
  parameter int MAX_SIDES = MAX_SIDES_DEF
) (
  input logic       clk,
  input logic       rst,
  cvg_req_if.sink   req,
  cvg_rsp_if.source rsp,
  cvg_cfg_if.sink   cfg
);

  localparam int NW    = $clog2(MAX_SIDES + 1);
  localparam int CW    = NW + 2;
  localparam int XW    = (CW > IDX_W) ? CW : IDX_W;
  localparam int DSTG  = 8;
  localparam int DBITS = 4;
  localparam int S_RND = DSTG + 1;
  localparam int S_OCT = DSTG + 2;
  localparam int S_SC  = DSTG + 4 + SC_LAT;
  localparam int NSTG  = S_SC + 3;

  typedef struct packed {
    logic        present;
    logic        is_final;
    logic        ring_ok;
    logic [15:0] y;
    logic [15:0] u;
    logic [14:0] radius;
    logic [15:0] v;
    logic [2:0]  oct;
  } meta_t;

  // Configuration registers.
  logic signed [15:0] height;
  logic signed [15:0] bottom_radius;
  logic signed [15:0] top_radius;
  logic [8:0]         side_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      height        <= HEIGHT_RST;
      bottom_radius <= BOTTOM_RST;
      top_radius    <= TOP_RST;
      side_count    <= SIDES_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_HEIGHT:        height        <= cfg.data;
        REG_BOTTOM_RADIUS: bottom_radius <= cfg.data;
        REG_TOP_RADIUS:    top_radius    <= cfg.data;
        REG_SIDE_COUNT:    side_count    <= cfg.data[8:0];
        default:           ;
      endcase
    end
  end

  logic              en;
  logic [NSTG-1:0]   vld;
  meta_t             meta_q [S_SC+1];

  assign en        = !vld[NSTG-1] || rsp.ready;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], req.valid};
    end
  end

  // Decode of the vertex number against the mesh layout.
  logic [NW-1:0]      n_sat;
  logic [CW-1:0]      nb;
  logic [CW-1:0]      nt;
  logic [XW-1:0]      idx;
  logic [XW-1:0]      top_c;
  logic [XW-1:0]      count;
  logic [XW-1:0]      kx;
  logic [NW-1:0]      k;
  logic [NW-1:0]      m;
  logic signed [15:0] h2;
  meta_t              meta_dec;

  always_comb begin
    if (32'(side_count) > 32'(MAX_SIDES)) begin
      n_sat = NW'(MAX_SIDES);
    end else begin
      n_sat = NW'(side_count);
    end
    nb    = (bottom_radius > 16'sd0) ? CW'(n_sat) : '0;
    nt    = (top_radius > 16'sd0) ? CW'(n_sat) : '0;
    idx   = XW'(req.vertex_index);
    top_c = XW'(nb) + XW'(1);
    count = XW'(nb) + XW'(nt) + XW'(2);
    h2    = (height + $signed({15'd0, height[15]})) >>> 1;

    meta_dec          = '0;
    meta_dec.present  = idx < count;
    meta_dec.is_final = idx == (count - XW'(1));
    meta_dec.u        = TEX_HALF;
    meta_dec.v        = TEX_HALF;
    kx                = '0;
    priority if (idx == '0) begin
      meta_dec.y = -h2;
    end else if (idx < top_c) begin
      meta_dec.ring_ok = 1'b1;
      meta_dec.y       = -h2;
      meta_dec.u       = '0;
      meta_dec.radius  = bottom_radius[14:0];
      kx               = idx - XW'(1);
    end else if (idx == top_c) begin
      meta_dec.y = h2;
    end else begin
      meta_dec.ring_ok = 1'b1;
      meta_dec.y       = h2;
      meta_dec.u       = TEX_ONE;
      meta_dec.radius  = top_radius[14:0];
      kx               = idx - top_c - XW'(1);
    end
    meta_dec.ring_ok = meta_dec.ring_ok && (n_sat != '0);
    k = NW'(kx);
    m = ({k, 1'b0} > {1'b0, n_sat}) ? (n_sat - k) : k;
  end

  // Long division: turn = k * 2^32 / n and v = m * 2^16 / n, remainders kept.
  logic [NW-1:0] dn  [DSTG+1];
  logic [NW-1:0] drt [DSTG+1];
  logic [31:0]   dqt [DSTG+1];
  logic [NW-1:0] drv [DSTG+1];
  logic [15:0]   dqv [DSTG+1];

  always_ff @(posedge clk) begin
    if (en) begin
      meta_q[0] <= meta_dec;
      dn[0]     <= n_sat;
      drt[0]    <= k;
      dqt[0]    <= '0;
      drv[0]    <= m;
      dqv[0]    <= '0;
    end
  end

  for (genvar s = 1; s <= DSTG; s++) begin : g_div
    logic [NW-1:0] rt;
    logic [31:0]   qt;
    logic [NW-1:0] rv;
    logic [15:0]   qv;

    always_comb begin
      logic [NW:0] rw;
      rt = drt[s-1];
      qt = dqt[s-1];
      rv = drv[s-1];
      qv = dqv[s-1];
      for (int j = 0; j < DBITS; j++) begin
        rw = {rt, 1'b0};
        if (rw >= {1'b0, dn[s-1]}) begin
          rw = rw - {1'b0, dn[s-1]};
          qt = {qt[30:0], 1'b1};
        end else begin
          qt = {qt[30:0], 1'b0};
        end
        rt = rw[NW-1:0];
      end
      if (s * DBITS <= 16) begin
        for (int j = 0; j < DBITS; j++) begin
          rw = {rv, 1'b0};
          if (rw >= {1'b0, dn[s-1]}) begin
            rw = rw - {1'b0, dn[s-1]};
            qv = {qv[14:0], 1'b1};
          end else begin
            qv = {qv[14:0], 1'b0};
          end
          rv = rw[NW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        meta_q[s] <= meta_q[s-1];
        dn[s]     <= dn[s-1];
        drt[s]    <= rt;
        dqt[s]    <= qt;
        drv[s]    <= rv;
        dqv[s]    <= qv;
      end
    end
  end

  // Round to nearest: a remainder of at least half the divisor rounds up.
  logic [NW-1:0] half_up;
  logic [31:0]   turn;
  logic [29:0]   r_oct;
  logic [44:0]   p_lo;
  logic [44:0]   p_hi;
  logic [29:0]   angle;
  logic [60:0]   a_sum;
  meta_t         meta_rnd;
  meta_t         meta_oct;

  assign half_up = dn[DSTG] - (dn[DSTG] >> 1);
  assign a_sum   = {1'b0, p_hi, 15'd0} + 61'(p_lo) + (61'd1 << 28);

  always_comb begin
    meta_rnd   = meta_q[DSTG];
    meta_rnd.v = dqv[DSTG] + 16'(drv[DSTG] >= half_up);
    meta_oct     = meta_q[S_RND];
    meta_oct.oct = turn[31:29];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_q[S_RND] <= meta_rnd;
      turn          <= dqt[DSTG] + 32'(drt[DSTG] >= half_up);

      meta_q[S_OCT] <= meta_oct;
      r_oct <= turn[29] ? (30'd1 << 29) - 30'(turn[28:0]) : 30'(turn[28:0]);

      meta_q[S_OCT+1] <= meta_q[S_OCT];
      p_lo <= 45'(r_oct[14:0]) * 45'(QUARTER_PI_Q30);
      p_hi <= 45'(r_oct[29:15]) * 45'(QUARTER_PI_Q30);

      meta_q[S_OCT+2] <= meta_q[S_OCT+1];
      angle           <= a_sum[58:29];
    end
  end

  logic [30:0] sin_q;
  logic [30:0] cos_q;

  cvg_sincos u_sincos (
    .clk   (clk),
    .en    (en),
    .angle (angle),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  for (genvar s = S_OCT + 3; s <= S_SC; s++) begin : g_delay
    always_ff @(posedge clk) begin
      if (en) begin
        meta_q[s] <= meta_q[s-1];
      end
    end
  end

  // Octant symmetry: swap sine and cosine and set signs, then scale by radius.
  logic [2:0]  oct;
  logic [30:0] cm;
  logic [30:0] sm;
  logic [45:0] px;
  logic [45:0] pz;
  meta_t       meta_f;
  logic [46:0] rx;
  logic [46:0] rz;
  logic [15:0] mag_x;
  logic [15:0] mag_z;

  assign oct = meta_q[S_SC].oct;
  assign cm  = (oct[0] ^ oct[1]) ? sin_q : cos_q;
  assign sm  = (oct[0] ^ oct[1]) ? cos_q : sin_q;

  always_ff @(posedge clk) begin
    if (en) begin
      meta_f <= meta_q[S_SC];
      px     <= 46'(meta_q[S_SC].radius) * 46'(cm);
      pz     <= 46'(meta_q[S_SC].radius) * 46'(sm);
    end
  end

  assign rx    = 47'(px) + (47'd1 << 29);
  assign rz    = 47'(pz) + (47'd1 << 29);
  assign mag_x = rx[45:30];
  assign mag_z = rz[45:30];

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.present  <= meta_f.present;
      rsp.is_final <= meta_f.present && meta_f.is_final;
      rsp.pos_y    <= meta_f.present ? meta_f.y : '0;
      rsp.tex_u    <= meta_f.present ? meta_f.u : '0;
      if (meta_f.present && meta_f.ring_ok) begin
        rsp.pos_x <= (meta_f.oct[1] ^ meta_f.oct[2]) ? -mag_x : mag_x;
        rsp.pos_z <= meta_f.oct[2] ? -mag_z : mag_z;
        rsp.tex_v <= meta_f.v;
      end else begin
        rsp.pos_x <= '0;
        rsp.pos_z <= '0;
        rsp.tex_v <= meta_f.present ? TEX_HALF : '0;
      end
    end
  end

  assign rsp.valid = vld[NSTG-1];

endmodule

[hw/rtl/cvg_checker.sv]
// Port level assertions of the cone vertex generator and their binding.
`timescale 1ns / 1ps

module cvg_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        present,
  input logic        is_final,
  input logic [15:0] pos_x,
  input logic [15:0] pos_y,
  input logic [15:0] pos_z,
  input logic [15:0] tex_u,
  input logic [15:0] tex_v
);

  // A held result stays valid and keeps pos_x, pos_z, tex_v and present until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(pos_x) && $stable(pos_z)
      && $stable(tex_v) && $stable(present))
    else $error("result changed while stalled");

  // A stalled output blocks new input.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("input accepted while output stalled");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !present |-> !is_final && pos_x == 16'd0 && pos_y == 16'd0
      && pos_z == 16'd0 && tex_u == 16'd0 && tex_v == 16'd0)
    else $error("vertex outside mesh has nonzero fields");

  // Cap centres sit on the axis with centered texture coordinates.
  a_centre: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && present && tex_u == 16'd16384 |->
      pos_x == 16'd0 && pos_z == 16'd0 && tex_v == 16'd16384)
    else $error("cap centre off axis");

endmodule

bind cone_vertex_generator_core cvg_checker u_cvg_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .present   (rsp.present),
  .is_final  (rsp.is_final),
  .pos_x     (rsp.pos_x),
  .pos_y     (rsp.pos_y),
  .pos_z     (rsp.pos_z),
  .tex_u     (rsp.tex_u),
  .tex_v     (rsp.tex_v)
);
